>>> hdl/lspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd_pkg
// shared types and constants of the lidar scan deframer
// ----------------------------------------------------------------------------
package lspd_pkg;

  localparam int unsigned SCAN_BYTE_BUDGET   = 1980;
  localparam int unsigned PACKETS_PER_SCAN   = 90;
  localparam int unsigned READINGS_PER_FRAME = 360;

  localparam logic [1:0] MODE_FRAME  = 2'd1;
  localparam logic [1:0] MODE_PACKET = 2'd2;

  localparam logic [7:0] SYNC0    = 8'h5A;
  localparam logic [7:0] SYNC1    = 8'hA5;
  localparam logic [7:0] SYNC2    = 8'h00;
  localparam logic [7:0] SYNC3    = 8'hC0;
  localparam logic [7:0] HDR_BYTE = 8'hFA;
  localparam logic [7:0] IDX_BASE = 8'hA0;

  localparam logic [8:0] LAST_BEARING = 9'd359;
  localparam logic [4:0] PKT_LAST_POS = 5'd21;
  localparam logic [4:0] PKT_END_POS  = 5'd20;
  localparam logic [4:0] PKT_LEN      = 5'd22;
  localparam logic [4:0] DIV_STEPS    = 5'd17;

  localparam logic KIND_READING = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT0, PH_HUNT1, PH_HUNT2, PH_HUNT3, PH_BODY, PH_HDR, PH_IDX, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    C_IDLE, C_RD, C_EMIT, C_DIV, C_SUM
  } ctl_t;

  typedef struct packed {
    logic        result_kind;
    logic [8:0]  bearing_index;
    logic [13:0] range_mm;
    logic        no_return_flag;
    logic        too_close_flag;
    logic [15:0] intensity;
    logic [15:0] motor_speed;
    logic [6:0]  good_packet_count;
    logic        last_of_run;
  } res_t;

endpackage

>>> hdl/lspd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd channel interfaces
// byte input channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface lspd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lspd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [8:0]  bearing_index;
  logic [13:0] range_mm;
  logic        no_return_flag;
  logic        too_close_flag;
  logic [15:0] intensity;
  logic [15:0] motor_speed;
  logic [6:0]  good_packet_count;
  logic        last_of_run;
  modport source (output valid, output result_kind, output bearing_index, output range_mm,
                  output no_return_flag, output too_close_flag, output intensity,
                  output motor_speed, output good_packet_count, output last_of_run,
                  input ready);
  modport sink (input valid, input result_kind, input bearing_index, input range_mm,
                input no_return_flag, input too_close_flag, input intensity,
                input motor_speed, input good_packet_count, input last_of_run,
                output ready);
endinterface

>>> hdl/lidar_scan_packet_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_packet_deframer_top
// rebuilds lidar scans from a serial byte stream, frame or packet format
// ----------------------------------------------------------------------------
// one byte beat is taken per visit to idle. a byte that yields readings
// sends each reading through a payload ram read and an output load. an
// end of scan in mode 2 runs the restoring divider (one quotient bit per
// cycle) for the speed average, then loads the summary beat; mode 1 loads
// the summary beat straight away. output backpressure holds the reading
// and summary loads. the result register lets the next byte be taken while
// the last result beat still waits. a cfg write aborts any scan in progress
// and restarts the sync hunt.
module lidar_scan_packet_deframer_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata,
  lspd_in_if.sink          in_if,
  lspd_out_if.source       out_if
);

  // parse state
  lspd_pkg::phase_t phase_r, phase_nxt;
  logic [10:0] sbc_r, sbc_nxt;        // bytes into the scan
  logic [4:0]  pbp_r, pbp_nxt;        // byte position in packet / reading
  logic [6:0]  cpi_r, cpi_nxt;        // current packet index
  logic [16:0] ss_r, ss_nxt;          // speed sum
  logic [6:0]  gp_r, gp_nxt;          // good packets
  logic [15:0] fsw_r, fsw_nxt;        // mode 1 speed word
  logic [8:0]  rc_r, rc_nxt;          // mode 1 reading count
  logic [15:0] spw_r, spw_nxt;        // speed word of packet being received
  logic [1:0]  mode_r;

  // payload ram: four rows of one reading each
  logic [31:0] mem [4];
  logic [31:0] rd_data_r;
  logic        mem_we;
  logic [1:0]  mem_wa;
  logic [1:0]  mem_lane;

  // sequencer
  lspd_pkg::ctl_t ctl_r, ctl_nxt;
  logic [2:0]  n_rd_r, n_rd_nxt;      // readings to send
  logic [2:0]  rdi_r;                 // reading being sent
  logic        sum_r, sum_nxt;        // summary pending
  logic        run_m1_r;              // results come from mode 1
  logic [8:0]  base_r, base_nxt;      // bearing of first reading
  logic [7:0]  byte_r;

  // divider
  logic [16:0] quo_r;
  logic [6:0]  rem_r;
  logic [6:0]  dcnt_r, dcnt_nxt;
  logic [4:0]  dstep_r;
  logic [7:0]  trial;
  logic [8:0]  diff;

  lspd_pkg::res_t out_r;
  logic           out_valid_r;
  logic           slot_free;
  logic           accept;
  logic           load_rd, load_sum;

  assign accept    = in_if.valid && in_if.ready;
  assign in_if.ready = (ctl_r == lspd_pkg::C_IDLE) && !cfg_we;
  assign slot_free = !out_valid_r || out_if.ready;

  // ---------------- byte parser ----------------
  always_comb begin
    logic [7:0]  idx;
    logic [11:0] hdr_end;
    logic        hdr_ok;
    logic [8:0]  rc_inc;
    logic [10:0] sbc_inc;
    logic        do_count;
    phase_nxt = phase_r;
    sbc_nxt   = sbc_r;
    pbp_nxt   = pbp_r;
    cpi_nxt   = cpi_r;
    ss_nxt    = ss_r;
    gp_nxt    = gp_r;
    fsw_nxt   = fsw_r;
    rc_nxt    = rc_r;
    spw_nxt   = spw_r;
    n_rd_nxt  = 3'd0;
    sum_nxt   = 1'b0;
    base_nxt  = rc_r;
    mem_we    = 1'b0;
    mem_wa    = 2'd0;
    mem_lane  = pbp_r[1:0];
    do_count  = 1'b0;
    idx       = in_if.rx_byte - lspd_pkg::IDX_BASE;
    hdr_end   = {1'b0, sbc_r} + 12'(lspd_pkg::PKT_LEN);
    hdr_ok    = (in_if.rx_byte == lspd_pkg::HDR_BYTE) &&
                (hdr_end <= 12'(lspd_pkg::SCAN_BYTE_BUDGET));
    rc_inc    = rc_r + 9'd1;
    sbc_inc   = sbc_r + 11'd1;
    if (mode_r == lspd_pkg::MODE_FRAME) begin
      case (phase_r)
        lspd_pkg::PH_HUNT0: if (in_if.rx_byte == lspd_pkg::SYNC0) phase_nxt = lspd_pkg::PH_HUNT1;
        lspd_pkg::PH_HUNT1: if (in_if.rx_byte == lspd_pkg::SYNC1) phase_nxt = lspd_pkg::PH_HUNT2;
        lspd_pkg::PH_HUNT2: if (in_if.rx_byte == lspd_pkg::SYNC2) phase_nxt = lspd_pkg::PH_HUNT3;
        lspd_pkg::PH_HUNT3: begin
          if (in_if.rx_byte == lspd_pkg::SYNC3) begin
            phase_nxt = lspd_pkg::PH_BODY;
            sbc_nxt   = 11'd0;
            pbp_nxt   = 5'd0;
            rc_nxt    = 9'd0;
            fsw_nxt   = 16'd0;
          end
        end
        lspd_pkg::PH_BODY: begin
          if (sbc_r == 11'd0) begin
            fsw_nxt = {8'd0, in_if.rx_byte};
            sbc_nxt = 11'd1;
          end else if (sbc_r == 11'd1) begin
            fsw_nxt = {in_if.rx_byte, fsw_r[7:0]};
            sbc_nxt = 11'd2;
          end else if (pbp_r < 5'd3) begin
            mem_we  = 1'b1;
            pbp_nxt = pbp_r + 5'd1;
          end else begin
            n_rd_nxt = 3'd1;
            pbp_nxt  = 5'd0;
            rc_nxt   = rc_inc;
            if (rc_inc >= 9'(lspd_pkg::READINGS_PER_FRAME)) begin
              sum_nxt   = 1'b1;
              phase_nxt = lspd_pkg::PH_HUNT0;
              sbc_nxt   = 11'd0;
              pbp_nxt   = 5'd0;
              cpi_nxt   = 7'd0;
              ss_nxt    = 17'd0;
              gp_nxt    = 7'd0;
              rc_nxt    = 9'd0;
            end
          end
        end
        default: phase_nxt = lspd_pkg::PH_HUNT0;
      endcase
    end else if (mode_r == lspd_pkg::MODE_PACKET) begin
      mem_wa   = 2'(pbp_r[4:2] - 3'd1);
      base_nxt = {cpi_r, 2'b00};
      case (phase_r)
        lspd_pkg::PH_HUNT0: if (in_if.rx_byte == lspd_pkg::HDR_BYTE) phase_nxt = lspd_pkg::PH_HUNT1;
        lspd_pkg::PH_HUNT1: begin
          if (in_if.rx_byte == lspd_pkg::IDX_BASE) begin
            phase_nxt = lspd_pkg::PH_BODY;
            sbc_nxt   = 11'd2;
            pbp_nxt   = 5'd2;
            cpi_nxt   = 7'd0;
            ss_nxt    = 17'd0;
            gp_nxt    = 7'd0;
            rc_nxt    = 9'd0;
          end else begin
            phase_nxt = lspd_pkg::PH_HUNT0;
          end
        end
        lspd_pkg::PH_HDR: begin
          do_count  = 1'b1;
          phase_nxt = hdr_ok ? lspd_pkg::PH_IDX : lspd_pkg::PH_HDR;
        end
        lspd_pkg::PH_IDX: begin
          do_count = 1'b1;
          if (idx < 8'(lspd_pkg::PACKETS_PER_SCAN)) begin
            cpi_nxt   = idx[6:0];
            pbp_nxt   = 5'd2;
            phase_nxt = lspd_pkg::PH_BODY;
          end else begin
            phase_nxt = hdr_ok ? lspd_pkg::PH_IDX : lspd_pkg::PH_HDR;
          end
        end
        lspd_pkg::PH_BODY: begin
          do_count = 1'b1;
          if (in_if.rx_byte == lspd_pkg::HDR_BYTE) begin
            phase_nxt = hdr_ok ? lspd_pkg::PH_IDX : lspd_pkg::PH_HDR;
          end else if (pbp_r < lspd_pkg::PKT_LAST_POS) begin
            if (pbp_r == 5'd2) spw_nxt = {spw_r[15:8], in_if.rx_byte};
            if (pbp_r == 5'd3) spw_nxt = {in_if.rx_byte, spw_r[7:0]};
            if (pbp_r >= 5'd4 && pbp_r < lspd_pkg::PKT_END_POS) mem_we = 1'b1;
            pbp_nxt = pbp_r + 5'd1;
          end else begin
            gp_nxt    = gp_r + 7'd1;
            ss_nxt    = ss_r + 17'(spw_r[15:6]);
            n_rd_nxt  = 3'd4;
            phase_nxt = ({cpi_r, 2'b11} == lspd_pkg::LAST_BEARING) ?
                        lspd_pkg::PH_DONE : lspd_pkg::PH_HDR;
          end
        end
        lspd_pkg::PH_DONE: do_count = 1'b1;
        default: do_count = 1'b1;
      endcase
      if (do_count) begin
        sbc_nxt = sbc_inc;
        if (sbc_inc >= 11'(lspd_pkg::SCAN_BYTE_BUDGET)) begin
          sum_nxt   = 1'b1;
          phase_nxt = lspd_pkg::PH_HUNT0;
          sbc_nxt   = 11'd0;
          pbp_nxt   = 5'd0;
          cpi_nxt   = 7'd0;
          ss_nxt    = 17'd0;
          gp_nxt    = 7'd0;
          rc_nxt    = 9'd0;
        end
      end
    end
  end

  // divider snapshot: values after this byte's packet, before the scan clear
  always_comb begin
    dcnt_nxt = gp_r;
    if (mode_r == lspd_pkg::MODE_PACKET && phase_r == lspd_pkg::PH_BODY &&
        in_if.rx_byte != lspd_pkg::HDR_BYTE && pbp_r >= lspd_pkg::PKT_LAST_POS) begin
      dcnt_nxt = gp_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lspd_pkg::MODE_PACKET;
      phase_r <= lspd_pkg::PH_HUNT0;
      sbc_r   <= '0;
      pbp_r   <= '0;
      cpi_r   <= '0;
      ss_r    <= '0;
      gp_r    <= '0;
      rc_r    <= '0;
      fsw_r   <= '0;
      spw_r   <= '0;
    end else if (cfg_we) begin
      mode_r  <= cfg_wdata;
      phase_r <= lspd_pkg::PH_HUNT0;
      sbc_r   <= '0;
      pbp_r   <= '0;
      cpi_r   <= '0;
      ss_r    <= '0;
      gp_r    <= '0;
      rc_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      sbc_r   <= sbc_nxt;
      pbp_r   <= pbp_nxt;
      cpi_r   <= cpi_nxt;
      ss_r    <= ss_nxt;
      gp_r    <= gp_nxt;
      rc_r    <= rc_nxt;
      fsw_r   <= fsw_nxt;
      spw_r   <= spw_nxt;
    end
  end

  // ---------------- payload ram ----------------
  always_ff @(posedge clk) begin
    if (accept && mem_we) mem[mem_wa][mem_lane*8 +: 8] <= in_if.rx_byte;
    if (ctl_r == lspd_pkg::C_RD) rd_data_r <= mem[run_m1_r ? 2'd0 : rdi_r[1:0]];
  end

  // ---------------- sequencer ----------------
  always_comb begin
    ctl_nxt = ctl_r;
    case (ctl_r)
      lspd_pkg::C_IDLE: begin
        if (accept) begin
          if (n_rd_nxt != 3'd0) ctl_nxt = lspd_pkg::C_RD;
          else if (sum_nxt) ctl_nxt = (mode_r == lspd_pkg::MODE_FRAME) ?
                                      lspd_pkg::C_SUM : lspd_pkg::C_DIV;
        end
      end
      lspd_pkg::C_RD: ctl_nxt = lspd_pkg::C_EMIT;
      lspd_pkg::C_EMIT: begin
        if (slot_free) begin
          if (rdi_r + 3'd1 < n_rd_r) ctl_nxt = lspd_pkg::C_RD;
          else if (sum_r) ctl_nxt = run_m1_r ? lspd_pkg::C_SUM : lspd_pkg::C_DIV;
          else ctl_nxt = lspd_pkg::C_IDLE;
        end
      end
      lspd_pkg::C_DIV: if (dstep_r == lspd_pkg::DIV_STEPS - 5'd1) ctl_nxt = lspd_pkg::C_SUM;
      lspd_pkg::C_SUM: if (slot_free) ctl_nxt = lspd_pkg::C_IDLE;
      default: ctl_nxt = lspd_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    load_rd  = (ctl_r == lspd_pkg::C_EMIT) && slot_free;
    load_sum = (ctl_r == lspd_pkg::C_SUM) && slot_free;
  end

  // divider step: one quotient bit per cycle
  assign trial = {rem_r, quo_r[16]};
  assign diff  = {1'b0, trial} - {2'b00, dcnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= lspd_pkg::C_IDLE;
      rdi_r <= '0;
      n_rd_r <= '0;
      sum_r <= 1'b0;
      run_m1_r <= 1'b0;
    end else begin
      ctl_r <= ctl_nxt;
      if (accept) begin
        rdi_r    <= '0;
        n_rd_r   <= n_rd_nxt;
        sum_r    <= sum_nxt;
        run_m1_r <= (mode_r == lspd_pkg::MODE_FRAME);
      end else if (load_rd) begin
        rdi_r <= rdi_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r  <= in_if.rx_byte;
      base_r  <= base_nxt;
      quo_r   <= ss_r + ((dcnt_nxt != gp_r) ? 17'(spw_r[15:6]) : 17'd0);
      rem_r   <= '0;
      dcnt_r  <= dcnt_nxt;
      dstep_r <= '0;
    end else if (ctl_r == lspd_pkg::C_DIV) begin
      dstep_r <= dstep_r + 5'd1;
      if (!diff[8]) begin
        rem_r <= diff[6:0];
        quo_r <= {quo_r[15:0], 1'b1};
      end else begin
        rem_r <= trial[6:0];
        quo_r <= {quo_r[15:0], 1'b0};
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_rd || load_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rd) begin
      out_r.result_kind       <= lspd_pkg::KIND_READING;
      out_r.bearing_index     <= base_r + 9'(rdi_r);
      out_r.range_mm          <= {rd_data_r[13:8], rd_data_r[7:0]};
      out_r.no_return_flag    <= run_m1_r & rd_data_r[15];
      out_r.too_close_flag    <= run_m1_r & rd_data_r[14];
      out_r.intensity         <= run_m1_r ? {byte_r, rd_data_r[23:16]} : rd_data_r[31:16];
      out_r.motor_speed       <= '0;
      out_r.good_packet_count <= '0;
      out_r.last_of_run       <= (rdi_r + 3'd1 >= n_rd_r) && !sum_r;
    end else if (load_sum) begin
      out_r.result_kind       <= lspd_pkg::KIND_SUMMARY;
      out_r.bearing_index     <= '0;
      out_r.range_mm          <= '0;
      out_r.no_return_flag    <= 1'b0;
      out_r.too_close_flag    <= 1'b0;
      out_r.intensity         <= '0;
      out_r.motor_speed       <= run_m1_r ? fsw_r :
                                 ((dcnt_r == 7'd0) ? 16'd0 : quo_r[15:0]);
      out_r.good_packet_count <= run_m1_r ? 7'd0 : dcnt_r;
      out_r.last_of_run       <= 1'b1;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.result_kind       = out_r.result_kind;
  assign out_if.bearing_index     = out_r.bearing_index;
  assign out_if.range_mm          = out_r.range_mm;
  assign out_if.no_return_flag    = out_r.no_return_flag;
  assign out_if.too_close_flag    = out_r.too_close_flag;
  assign out_if.intensity         = out_r.intensity;
  assign out_if.motor_speed       = out_r.motor_speed;
  assign out_if.good_packet_count = out_r.good_packet_count;
  assign out_if.last_of_run       = out_r.last_of_run;

endmodule

>>> bench/tb_lidar_scan_packet_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_scan_packet_deframer_top
// self-checking bench for the lidar scan deframer: byte beats go in through
// the input channel, a scan predictor built into the scoreboard works out
// every reading and summary beat, and each result beat is checked in order
// ----------------------------------------------------------------------------

// scoreboard: scan predictor plus queue of pending result beats
class scan_scoreboard;
  bit [1:0]  frame_mode;
  lspd_pkg::phase_t phase;
  bit [10:0] scan_cnt;
  bit [4:0]  pkt_pos;
  bit [6:0]  pkt_idx;
  bit [7:0]  payload [18];
  bit [16:0] speed_sum;
  bit [6:0]  good_cnt;
  bit [15:0] frame_speed;
  bit [8:0]  reading_cnt;

  lspd_pkg::res_t pending_q [$];
  int   mismatches;
  int   beats_checked;
  int   summaries;

  function new();
    frame_mode = lspd_pkg::MODE_PACKET;
    frame_speed = '0;
    foreach (payload[i]) payload[i] = '0;
    restart_scan();
  endfunction

  function void restart_scan();
    phase = lspd_pkg::PH_HUNT0;
    scan_cnt = '0;
    pkt_pos = '0;
    pkt_idx = '0;
    speed_sum = '0;
    good_cnt = '0;
    reading_cnt = '0;
  endfunction

  function void set_mode(bit [1:0] m);
    frame_mode = m;
    restart_scan();
  endfunction

  function void add_beat(bit kind, bit [8:0] bearing, bit [13:0] range, bit nr, bit tc,
                         bit [15:0] inten, bit [15:0] speed, bit [6:0] cnt);
    lspd_pkg::res_t r;
    r = '0;
    r.result_kind = kind;
    r.bearing_index = bearing;
    r.range_mm = range;
    r.no_return_flag = nr;
    r.too_close_flag = tc;
    r.intensity = inten;
    r.motor_speed = speed;
    r.good_packet_count = cnt;
    pending_q = {pending_q, r};
  endfunction

  // frame format: 4-byte sync, speed word, then fixed count of readings
  function void frame_byte(bit [7:0] b);
    case (phase)
      lspd_pkg::PH_HUNT0: if (b == lspd_pkg::SYNC0) phase = lspd_pkg::PH_HUNT1;
      lspd_pkg::PH_HUNT1: if (b == lspd_pkg::SYNC1) phase = lspd_pkg::PH_HUNT2;
      lspd_pkg::PH_HUNT2: if (b == lspd_pkg::SYNC2) phase = lspd_pkg::PH_HUNT3;
      lspd_pkg::PH_HUNT3: begin
        if (b == lspd_pkg::SYNC3) begin
          phase = lspd_pkg::PH_BODY;
          scan_cnt = '0;
          pkt_pos = '0;
          reading_cnt = '0;
          frame_speed = '0;
        end
      end
      lspd_pkg::PH_BODY: begin
        if (scan_cnt == 0) begin
          frame_speed[7:0] = b;
          scan_cnt = 1;
        end else if (scan_cnt == 1) begin
          frame_speed[15:8] = b;
          scan_cnt = 2;
        end else if (pkt_pos < 3) begin
          payload[pkt_pos] = b;
          pkt_pos++;
        end else begin
          add_beat(lspd_pkg::KIND_READING, reading_cnt, {payload[1][5:0], payload[0]},
                   payload[1][7], payload[1][6], {b, payload[2]}, '0, '0);
          pkt_pos = '0;
          reading_cnt++;
          if (reading_cnt >= lspd_pkg::READINGS_PER_FRAME) begin
            add_beat(lspd_pkg::KIND_SUMMARY, '0, '0, 0, 0, '0, frame_speed, '0);
            restart_scan();
          end
        end
      end
      default: phase = lspd_pkg::PH_HUNT0;
    endcase
  endfunction

  function void take_header(bit [10:0] pos, bit [7:0] b);
    if (b == lspd_pkg::HDR_BYTE && int'(pos) + 22 <= lspd_pkg::SCAN_BYTE_BUDGET)
      phase = lspd_pkg::PH_IDX;
    else phase = lspd_pkg::PH_HDR;
  endfunction

  // packet format: byte budget per scan, 22-byte packets hunted inside it
  function void packet_byte(bit [7:0] b);
    bit [10:0] pos;
    bit [7:0]  idx;
    bit [15:0] word;
    bit [15:0] avg;
    int        p;
    pos = scan_cnt;
    if (phase == lspd_pkg::PH_HUNT0) begin
      if (b == lspd_pkg::HDR_BYTE) phase = lspd_pkg::PH_HUNT1;
      return;
    end
    if (phase == lspd_pkg::PH_HUNT1) begin
      if (b == lspd_pkg::IDX_BASE) begin
        restart_scan();
        scan_cnt = 2;
        pkt_pos = 2;
        phase = lspd_pkg::PH_BODY;
      end else begin
        phase = lspd_pkg::PH_HUNT0;
      end
      return;
    end
    case (phase)
      lspd_pkg::PH_HDR: take_header(pos, b);
      lspd_pkg::PH_IDX: begin
        idx = b - lspd_pkg::IDX_BASE;
        if (idx < lspd_pkg::PACKETS_PER_SCAN) begin
          pkt_idx = idx[6:0];
          pkt_pos = 2;
          phase = lspd_pkg::PH_BODY;
        end else begin
          take_header(pos, b);
        end
      end
      lspd_pkg::PH_BODY: begin
        if (b == lspd_pkg::HDR_BYTE) begin
          take_header(pos, b);
        end else if (pkt_pos < lspd_pkg::PKT_LAST_POS) begin
          if (pkt_pos >= 2 && pkt_pos < lspd_pkg::PKT_END_POS) payload[pkt_pos - 2] = b;
          pkt_pos++;
        end else begin
          word = {payload[1], payload[0]};
          good_cnt++;
          speed_sum = speed_sum + (word >> 6);
          for (int r = 0; r < 4; r++) begin
            p = 2 + 4 * r;
            add_beat(lspd_pkg::KIND_READING, 9'(4 * pkt_idx + r),
                     {payload[p+1][5:0], payload[p]},
                     0, 0, {payload[p+3], payload[p+2]}, '0, '0);
          end
          phase = (9'(4 * pkt_idx + 3) == lspd_pkg::LAST_BEARING) ?
                  lspd_pkg::PH_DONE : lspd_pkg::PH_HDR;
        end
      end
      default: ;
    endcase
    scan_cnt++;
    if (scan_cnt >= lspd_pkg::SCAN_BYTE_BUDGET) begin
      avg = '0;
      if (speed_sum > 0 && good_cnt > 0) avg = 16'(speed_sum / good_cnt);
      add_beat(lspd_pkg::KIND_SUMMARY, '0, '0, 0, 0, '0, avg, good_cnt);
      restart_scan();
    end
  endfunction

  // one accepted byte beat: predict its results, flag the last one
  function void note_byte(bit [7:0] b);
    int before_n;
    before_n = pending_q.size();
    if (frame_mode == lspd_pkg::MODE_FRAME) frame_byte(b);
    else if (frame_mode == lspd_pkg::MODE_PACKET) packet_byte(b);
    if (pending_q.size() > before_n) pending_q[pending_q.size() - 1].last_of_run = 1'b1;
  endfunction

  function string fmt(lspd_pkg::res_t r);
    return $sformatf("kind=%0d brg=%0d rng=%0d nr=%0d tc=%0d int=%0d spd=%0d cnt=%0d last=%0d",
                     r.result_kind, r.bearing_index, r.range_mm, r.no_return_flag,
                     r.too_close_flag, r.intensity, r.motor_speed, r.good_packet_count,
                     r.last_of_run);
  endfunction

  function void check_beat(lspd_pkg::res_t got);
    lspd_pkg::res_t exp_r;
    bit   bad;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("[%0t] unexpected result beat: %s", $realtime, fmt(got));
      return;
    end
    exp_r = pending_q.pop_front();
    beats_checked++;
    if (exp_r.result_kind == lspd_pkg::KIND_SUMMARY) summaries++;
    bad = (got.result_kind !== exp_r.result_kind) ||
          (got.bearing_index !== exp_r.bearing_index) ||
          (got.range_mm !== exp_r.range_mm) ||
          (got.no_return_flag !== exp_r.no_return_flag) ||
          (got.too_close_flag !== exp_r.too_close_flag) ||
          (got.intensity !== exp_r.intensity) ||
          (got.motor_speed !== exp_r.motor_speed) ||
          (got.good_packet_count !== exp_r.good_packet_count) ||
          (got.last_of_run !== exp_r.last_of_run);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] result mismatch", $realtime);
        $display("  expected %s", fmt(exp_r));
        $display("  actual   %s", fmt(got));
      end
    end
  endfunction
endclass

module tb_lidar_scan_packet_deframer_top;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  lspd_in_if  in_if ();
  lspd_out_if out_if ();

  lidar_scan_packet_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if.sink),
    .out_if    (out_if.source)
  );

  scan_scoreboard scan_sb;

  int in_idle_pct;   // chance in percent that the sender skips a cycle
  int out_idle_pct;  // chance in percent that the receiver stalls a cycle
  bit hold_req;      // asks the receiver for one long stall
  int hold_cnt;
  int bytes_sent;

  // free-running clock, 4 ns period
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: random stalls, plus one long stall on request
  initial begin
    out_if.ready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // result beats are checked at the rising edge they are taken on
  always @(posedge clk) begin
    lspd_pkg::res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.result_kind = out_if.result_kind;
      got.bearing_index = out_if.bearing_index;
      got.range_mm = out_if.range_mm;
      got.no_return_flag = out_if.no_return_flag;
      got.too_close_flag = out_if.too_close_flag;
      got.intensity = out_if.intensity;
      got.motor_speed = out_if.motor_speed;
      got.good_packet_count = out_if.good_packet_count;
      got.last_of_run = out_if.last_of_run;
      scan_sb.check_beat(got);
    end
  end

  // one byte beat, with a random gap in front of it
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if ($urandom_range(99) < in_idle_pct) begin
      in_if.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_if.valid = 1'b1;
    in_if.rx_byte = b;
    do @(posedge clk); while (!in_if.ready);
    scan_sb.note_byte(b);
    bytes_sent++;
  endtask

  // stop offering and wait until every predicted beat has come out
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (scan_sb.pending_q.size() != 0) @(posedge clk);
    // room for a summary divide still running behind the last beat
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    scan_sb.set_mode(m);
  endtask

  // any byte but the packet header, so a body stays intact
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == lspd_pkg::HDR_BYTE);
    return b;
  endfunction

  // 20 bytes after header and index; fill < 0 means random content,
  // broken puts a premature header at a random spot
  task automatic send_body(input int fill, input bit broken);
    int bad_at;
    bad_at = broken ? $urandom_range(19) : -1;
    for (int i = 0; i < 20; i++) begin
      if (i == bad_at) send_byte(lspd_pkg::HDR_BYTE);
      else if (fill >= 0) send_byte(8'(fill));
      else send_byte(body_byte());
    end
  endtask

  task automatic send_packet(input int idx, input bit broken);
    send_byte(lspd_pkg::HDR_BYTE);
    send_byte(lspd_pkg::IDX_BASE + 8'(idx));
    send_body(-1, broken);
  endtask

  // start of a frame-format scan, sync salted with stray bytes, then a few readings
  task automatic frame_run(input int readings);
    logic [7:0] sync_b [4];
    sync_b = '{lspd_pkg::SYNC0, lspd_pkg::SYNC1, lspd_pkg::SYNC2, lspd_pkg::SYNC3};
    foreach (sync_b[i]) begin
      if ($urandom_range(2) == 0) send_byte(8'h33);
      send_byte(sync_b[i]);
    end
    repeat (2 + 4 * readings) send_byte(8'($urandom));
  endtask

  // mode 2 noise: random bytes with headers and index bytes mixed in
  task automatic packet_noise(input int n);
    repeat (n) begin
      case ($urandom_range(3))
        0: send_byte(lspd_pkg::HDR_BYTE);
        1: send_byte(lspd_pkg::IDX_BASE + 8'($urandom_range(95)));
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    hold_req = 1'b0;
    bytes_sent = 0;
    in_idle_pct = 23;
    out_idle_pct = 84;
    scan_sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // phase 1, sender mostly busy, receiver mostly stalled
    // packet format out of reset: broken sync, then sync and packets with
    // extreme content, a dropped packet and a repeated index
    send_byte(8'h00);
    send_byte(lspd_pkg::HDR_BYTE);
    send_byte(lspd_pkg::HDR_BYTE);        // not A0 after header: hunt restarts here
    send_byte(lspd_pkg::HDR_BYTE);
    send_byte(lspd_pkg::IDX_BASE);        // scan sync, first packet has index 0
    send_body(8'hFF, 1'b0);               // all ones: max range, intensity and speed
    send_packet(0, 1'b0);                 // repeat of index 0 is still reported
    send_packet(1, 1'b1);                 // premature header drops this one
    send_byte(lspd_pkg::HDR_BYTE);
    send_byte(lspd_pkg::IDX_BASE + 8'd90);  // index out of range
    send_packet(2, 1'b0);

    // frame format: partial sync, then the start of a frame
    write_mode(lspd_pkg::MODE_FRAME);
    send_byte(lspd_pkg::SYNC0);
    send_byte(8'h77);                     // stray byte keeps the partial match
    frame_run(6);

    // modes with no format: bytes dropped
    write_mode(2'd0);
    packet_noise(5);
    write_mode(2'd3);
    packet_noise(5);

    // phase 2: sender mostly idle, receiver mostly ready
    write_mode(lspd_pkg::MODE_PACKET);
    in_idle_pct = 84;
    out_idle_pct = 23;
    send_byte(lspd_pkg::HDR_BYTE);
    send_byte(lspd_pkg::IDX_BASE);
    send_body(-1, 1'b0);
    // sender pause until every result beat is out, scan left open
    drain();
    send_packet($urandom_range(89), 1'b0);

    // phase 3: no idling on either side
    in_idle_pct = 0;
    out_idle_pct = 0;
    // long receiver stall while bytes keep coming: the block backs up
    hold_req = 1'b1;
    send_packet($urandom_range(89), 1'b0);
    packet_noise(8);

    drain();
    $display("run covered %0d byte beats in packet, frame and idle modes, %0d result beats",
             bytes_sent, scan_sb.beats_checked);
    $display("summaries %0d, mismatches %0d, beats still expected %0d",
             scan_sb.summaries, scan_sb.mismatches, scan_sb.pending_q.size());
    if (scan_sb.mismatches == 0 && scan_sb.pending_q.size() == 0) begin
      $display("lidar_scan_packet_deframer_top regression: pass");
    end else begin
      $display("lidar_scan_packet_deframer_top regression: fail");
    end
    $finish;
  end

  // hang guard, well beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("timeout waiting on the block");
    $display("lidar_scan_packet_deframer_top regression: fail");
    $finish;
  end

endmodule
